FILE: rtl/tlbrw_pkg.sv
// ============================================================================
// TLB translate/probe/read/write package
// Shared types and constants for the joint TLB block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
package tlbrw_pkg;

  localparam logic [1:0] MODE_TRANSLATE = 2'd0;
  localparam logic [1:0] MODE_PROBE     = 2'd1;
  localparam logic [1:0] MODE_READ      = 2'd2;
  localparam logic [1:0] MODE_WRITE     = 2'd3;

  localparam logic [1:0] ST_HIT      = 2'd0;
  localparam logic [1:0] ST_REFILL   = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_MODIFIED = 2'd3;

  localparam logic [1:0] EXC_LOAD  = 2'd0;
  localparam logic [1:0] EXC_STORE = 2'd1;
  localparam logic [1:0] EXC_MOD   = 2'd2;

  localparam int PAGE_SHIFT = 12;

  // One page half as stored: frame number, cache attribute, dirty, valid.
  typedef struct packed {
    logic [19:0] pfn;
    logic [2:0]  c;
    logic        d;
    logic        v;
  } page_t;

  // A transaction as classified by the front end.
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] vaddr;
    logic        is_store;
    logic        raise_exc;
    logic [7:0]  asid;
    logic [4:0]  index;
    logic [18:0] match_vpn;
    logic [15:0] wr_mask;
    logic [18:0] wr_vpn;
    logic        wr_g;
    page_t       wr_even;
    page_t       wr_odd;
  } item_t;

endpackage
`default_nettype wire

FILE: rtl/mips_tlb_translate_probe_rw_core.sv
// ============================================================================
// MIPS32-style joint TLB core
// Translate, probe, read-indexed and write-indexed on paired even/odd pages.
// ============================================================================
// Each transaction carries one of four operations and yields exactly one
// result transaction. The front end places accepted transactions in a
// two-entry queue, so input is taken until the queue is full while the back
// end is busy or the result waits to be taken. The back end handles one
// transaction at a time in S_IDLE, S_MATCH and S_RESULT: it takes it from the
// queue, compares every entry in parallel and registers the lowest matching
// index, then reads the selected entry and loads the result register once the
// output is free (a write-indexed updates the entry at that same point); only
// then does it take the next. The fault address register is to be written
// through cfg_we/cfg_wdata only while the block is idle; the block does not
// enforce this. All entries are cleared by reset.
`timescale 1ns / 1ps
`default_nettype none
module mips_tlb_translate_probe_rw_core #(
  parameter int TLB_ENTRIES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [31:0] in_vaddr,
  input  wire logic        in_is_store,
  input  wire logic        in_raise_exc,
  input  wire logic [7:0]  in_current_asid,
  input  wire logic [4:0]  in_entry_index,
  input  wire logic [15:0] in_wr_pagemask,
  input  wire logic [18:0] in_wr_vpn2,
  input  wire logic [19:0] in_wr_pfn_even,
  input  wire logic [5:0]  in_wr_flags_even,
  input  wire logic [19:0] in_wr_pfn_odd,
  input  wire logic [5:0]  in_wr_flags_odd,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_paddr,
  output logic [1:0]       out_status,
  output logic             out_dirty_out,
  output logic             out_exc_raised,
  output logic [1:0]       out_exc_code,
  output logic             out_probe_miss,
  output logic [4:0]       out_probe_index,
  output logic [15:0]      out_rd_pagemask,
  output logic [18:0]      out_rd_vpn2,
  output logic [7:0]       out_rd_asid,
  output logic [25:0]      out_rd_lo_even,
  output logic [25:0]      out_rd_lo_odd
);

  logic [31:0]      fault_address_r;
  logic             q_full, q_push, q_pop, q_not_empty;
  tlbrw_pkg::item_t q_item, q_head;

  // Physical address handed back when a translation fails.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_address_r <= 32'd0;
    end else if (cfg_we) begin
      fault_address_r <= cfg_wdata;
    end
  end

  tlbrw_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_vaddr         (in_vaddr),
    .in_is_store      (in_is_store),
    .in_raise_exc     (in_raise_exc),
    .in_current_asid  (in_current_asid),
    .in_entry_index   (in_entry_index),
    .in_wr_pagemask   (in_wr_pagemask),
    .in_wr_vpn2       (in_wr_vpn2),
    .in_wr_pfn_even   (in_wr_pfn_even),
    .in_wr_flags_even (in_wr_flags_even),
    .in_wr_pfn_odd    (in_wr_pfn_odd),
    .in_wr_flags_odd  (in_wr_flags_odd),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (q_item)
  );

  tlbrw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  tlbrw_back #(
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .fault_address   (fault_address_r),
    .q_not_empty     (q_not_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_paddr       (out_paddr),
    .out_status      (out_status),
    .out_dirty_out   (out_dirty_out),
    .out_exc_raised  (out_exc_raised),
    .out_exc_code    (out_exc_code),
    .out_probe_miss  (out_probe_miss),
    .out_probe_index (out_probe_index),
    .out_rd_pagemask (out_rd_pagemask),
    .out_rd_vpn2     (out_rd_vpn2),
    .out_rd_asid     (out_rd_asid),
    .out_rd_lo_even  (out_rd_lo_even),
    .out_rd_lo_odd   (out_rd_lo_odd)
  );

endmodule
`default_nettype wire

FILE: rtl/tlbrw_front.sv
// ============================================================================
// TLB front end
// Accepts transactions, picks the lookup key and prepares write data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module tlbrw_front (
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    in_mode,
  input  wire logic [31:0]   in_vaddr,
  input  wire logic          in_is_store,
  input  wire logic          in_raise_exc,
  input  wire logic [7:0]    in_current_asid,
  input  wire logic [4:0]    in_entry_index,
  input  wire logic [15:0]   in_wr_pagemask,
  input  wire logic [18:0]   in_wr_vpn2,
  input  wire logic [19:0]   in_wr_pfn_even,
  input  wire logic [5:0]    in_wr_flags_even,
  input  wire logic [19:0]   in_wr_pfn_odd,
  input  wire logic [5:0]    in_wr_flags_odd,
  input  wire logic          q_full,
  output logic               q_push,
  output tlbrw_pkg::item_t   q_item
);

  logic [16:0] mask_ext;
  logic [15:0] mask;

  // Keep only the trailing run of ones of the supplied mask.
  assign mask_ext = {1'b0, in_wr_pagemask} ^ ({1'b0, in_wr_pagemask} + 17'd1);
  assign mask     = mask_ext[16:1];

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item           = '0;
    q_item.mode      = in_mode;
    q_item.vaddr     = in_vaddr;
    q_item.is_store  = in_is_store;
    q_item.raise_exc = in_raise_exc;
    q_item.asid      = in_current_asid;
    q_item.index     = in_entry_index;
    q_item.match_vpn = (in_mode == tlbrw_pkg::MODE_TRANSLATE) ? in_vaddr[31:13] : in_wr_vpn2;
    q_item.wr_mask   = mask;
    q_item.wr_vpn    = in_wr_vpn2 & ~{3'b000, mask};
    q_item.wr_g      = in_wr_flags_even[0] & in_wr_flags_odd[0];
    q_item.wr_even.pfn = in_wr_pfn_even & ~{4'h0, mask};
    q_item.wr_even.c   = in_wr_flags_even[5:3];
    q_item.wr_even.d   = in_wr_flags_even[2];
    q_item.wr_even.v   = in_wr_flags_even[1];
    q_item.wr_odd.pfn  = in_wr_pfn_odd & ~{4'h0, mask};
    q_item.wr_odd.c    = in_wr_flags_odd[5:3];
    q_item.wr_odd.d    = in_wr_flags_odd[2];
    q_item.wr_odd.v    = in_wr_flags_odd[1];
  end

endmodule
`default_nettype wire

FILE: rtl/tlbrw_queue.sv
// ============================================================================
// TLB transaction queue
// Two-entry queue between the front end and the back end.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module tlbrw_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire tlbrw_pkg::item_t  push_item,
  output logic                   full,
  input  wire logic              pop,
  output logic                   not_empty,
  output tlbrw_pkg::item_t       head
);

  tlbrw_pkg::item_t slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tlbrw_back.sv
// ============================================================================
// TLB back end
// Holds the entries, matches them in parallel and registers the result.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module tlbrw_back #(
  parameter int TLB_ENTRIES = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [31:0]       fault_address,
  input  wire logic              q_not_empty,
  input  wire tlbrw_pkg::item_t  q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [31:0]            out_paddr,
  output logic [1:0]             out_status,
  output logic                   out_dirty_out,
  output logic                   out_exc_raised,
  output logic [1:0]             out_exc_code,
  output logic                   out_probe_miss,
  output logic [4:0]             out_probe_index,
  output logic [15:0]            out_rd_pagemask,
  output logic [18:0]            out_rd_vpn2,
  output logic [7:0]             out_rd_asid,
  output logic [25:0]            out_rd_lo_even,
  output logic [25:0]            out_rd_lo_odd
);

  localparam int IDX_W = $clog2(TLB_ENTRIES);

  typedef enum logic [1:0] {S_IDLE, S_MATCH, S_RESULT} state_t;

  state_t             state_r;
  tlbrw_pkg::item_t   item_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic               hit_r;

  logic [15:0]        mask_r  [TLB_ENTRIES];
  logic [18:0]        vpn_r   [TLB_ENTRIES];
  logic [7:0]         asid_r  [TLB_ENTRIES];
  logic               g_r     [TLB_ENTRIES];
  tlbrw_pkg::page_t   even_r  [TLB_ENTRIES];
  tlbrw_pkg::page_t   odd_r   [TLB_ENTRIES];

  logic [TLB_ENTRIES-1:0] match_vec;
  logic [IDX_W-1:0]   match_idx;
  logic               match_any;

  logic               in_range;
  logic [IDX_W-1:0]   rd_addr;
  logic [15:0]        e_mask;
  logic [18:0]        e_vpn;
  logic [7:0]         e_asid;
  logic               e_g;
  tlbrw_pkg::page_t   e_even, e_odd, e_page;
  logic [31:0]        span;
  logic               out_free;

  // Result register contents.
  logic [31:0] paddr_c;
  logic [1:0]  status_c, code_c;
  logic        dirty_c, exc_c, pmiss_c;
  logic [4:0]  pidx_c;
  logic [15:0] rmask_c;
  logic [18:0] rvpn_c;
  logic [7:0]  rasid_c;
  logic [25:0] rev_c, rod_c;

  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match_vec[i] = (((vpn_r[i] ^ item_r.match_vpn) & ~{3'b000, mask_r[i]}) == 19'd0) &&
                     (g_r[i] || (asid_r[i] == item_r.asid));
    end
  end

  always_comb begin
    match_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        match_idx = IDX_W'(i);
      end
    end
  end

  assign match_any = |match_vec;
  assign in_range  = (32'(item_r.index) < TLB_ENTRIES);
  assign rd_addr   = (item_r.mode == tlbrw_pkg::MODE_TRANSLATE) ? hit_idx_r
                                                                  : IDX_W'(item_r.index);
  assign e_mask    = mask_r[rd_addr];
  assign e_vpn     = vpn_r[rd_addr];
  assign e_asid    = asid_r[rd_addr];
  assign e_g       = g_r[rd_addr];
  assign e_even    = even_r[rd_addr];
  assign e_odd     = odd_r[rd_addr];
  assign span      = 32'({1'b0, e_mask} + 17'd1) << tlbrw_pkg::PAGE_SHIFT;
  assign e_page    = ((item_r.vaddr & span) != 32'd0) ? e_odd : e_even;
  assign out_free  = !out_valid || !out_stall;
  assign q_pop     = (state_r == S_IDLE) && q_not_empty;

  always_comb begin
    paddr_c = '0; status_c = '0; code_c = '0; dirty_c = 1'b0; exc_c = 1'b0;
    pmiss_c = 1'b0; pidx_c = '0; rmask_c = '0; rvpn_c = '0; rasid_c = '0;
    rev_c = '0; rod_c = '0;
    unique case (item_r.mode)
      tlbrw_pkg::MODE_TRANSLATE: begin
        code_c  = item_r.is_store ? tlbrw_pkg::EXC_STORE : tlbrw_pkg::EXC_LOAD;
        rasid_c = e_asid;
        if (!hit_r) begin
          status_c = tlbrw_pkg::ST_REFILL;
          rasid_c  = item_r.asid;
        end else if (!e_page.v) begin
          status_c = tlbrw_pkg::ST_INVALID;
        end else if (!e_page.d && item_r.is_store) begin
          status_c = tlbrw_pkg::ST_MODIFIED;
          code_c   = tlbrw_pkg::EXC_MOD;
        end else begin
          status_c = tlbrw_pkg::ST_HIT;
        end
        if (status_c == tlbrw_pkg::ST_HIT) begin
          paddr_c = {e_page.pfn, 12'h000} | (item_r.vaddr & (span - 32'd1));
          dirty_c = e_page.d;
          code_c  = tlbrw_pkg::EXC_LOAD;
          rasid_c = '0;
        end else begin
          paddr_c = fault_address;
          exc_c   = item_r.raise_exc;
          if (item_r.raise_exc) begin
            rvpn_c = item_r.vaddr[31:13];
          end else begin
            rasid_c = '0;
          end
        end
      end
      tlbrw_pkg::MODE_PROBE: begin
        pmiss_c = !hit_r;
        pidx_c  = hit_r ? 5'(hit_idx_r) : 5'd0;
      end
      tlbrw_pkg::MODE_READ: begin
        if (in_range) begin
          rmask_c = e_mask;
          rvpn_c  = e_vpn;
          rasid_c = e_asid;
          rev_c   = {e_even, e_g};
          rod_c   = {e_odd, e_g};
        end
      end
      tlbrw_pkg::MODE_WRITE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_not_empty) begin
            state_r <= S_MATCH;
          end
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
        end
        S_MATCH: begin
          state_r <= S_RESULT;
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_head;
    end
    if (state_r == S_MATCH) begin
      hit_idx_r <= match_idx;
      hit_r     <= match_any;
    end
    if (state_r == S_RESULT && out_free) begin
      out_paddr       <= paddr_c;
      out_status      <= status_c;
      out_dirty_out   <= dirty_c;
      out_exc_raised  <= exc_c;
      out_exc_code    <= code_c;
      out_probe_miss  <= pmiss_c;
      out_probe_index <= pidx_c;
      out_rd_pagemask <= rmask_c;
      out_rd_vpn2     <= rvpn_c;
      out_rd_asid     <= rasid_c;
      out_rd_lo_even  <= rev_c;
      out_rd_lo_odd   <= rod_c;
    end
  end

  // The entries come out of reset cleared, and a reset entry can match.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        mask_r[i] <= '0;
        vpn_r[i]  <= '0;
        asid_r[i] <= '0;
        g_r[i]    <= 1'b0;
        even_r[i] <= '0;
        odd_r[i]  <= '0;
      end
    end else if (state_r == S_RESULT && out_free &&
                 item_r.mode == tlbrw_pkg::MODE_WRITE && in_range) begin
      mask_r[IDX_W'(item_r.index)] <= item_r.wr_mask;
      vpn_r[IDX_W'(item_r.index)]  <= item_r.wr_vpn;
      asid_r[IDX_W'(item_r.index)] <= item_r.asid;
      g_r[IDX_W'(item_r.index)]    <= item_r.wr_g;
      even_r[IDX_W'(item_r.index)] <= item_r.wr_even;
      odd_r[IDX_W'(item_r.index)]  <= item_r.wr_odd;
    end
  end

endmodule
`default_nettype wire
